// ----- rtl/prbs_bert_checker_macros.svh -----
// Assertion macros used by the checker file pbc_checker.sv.
`ifndef PRBS_BERT_CHECKER_MACROS_SVH
`define PRBS_BERT_CHECKER_MACROS_SVH

// Checked only outside reset.
`define PBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pbc_pkg.sv -----
package pbc_pkg;

  localparam int CNT_W = 48;

  localparam int PAT_W   = 23;
  localparam int WERR_W  = 12;
  localparam int WCNT_W  = 9;
  localparam int CFG_W   = 12;
  localparam int CIDX_W  = 2;

  // pn_mode codes
  localparam logic [1:0] PN11 = 2'd0;
  localparam logic [1:0] PN15 = 2'd1;
  localparam logic [1:0] PN23 = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_PN_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LOCK_THR  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WIN_LIMIT = 2'd2;
  localparam logic [CIDX_W-1:0] REG_LOSS_THR  = 2'd3;

  // command codes
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [7:0]        LOCK_THR_RST  = 8'd10;
  localparam logic [7:0]        WIN_LIMIT_RST = 8'd10;
  localparam logic [WERR_W-1:0] LOSS_THR_RST  = 12'd20;

  localparam logic [PAT_W-1:0] MASK_PN11 = 23'h0007FF;
  localparam logic [PAT_W-1:0] MASK_PN15 = 23'h007FFF;
  localparam logic [PAT_W-1:0] MASK_PN23 = 23'h7FFFFF;

  typedef struct packed {
    logic             locked;
    logic [3:0]       byte_errors;
    logic [CNT_W-1:0] bits_received;
    logic [CNT_W-1:0] bits_in_sync;
    logic [CNT_W-1:0] total_errors;
    logic [CNT_W-1:0] sync_losses;
  } res_t;

endpackage

// ----- rtl/prbs_bert_checker.sv -----
// PRBS bit error checker (PN11/PN15/PN23), one byte word per clock while
// in_ready is high. A word is taken when in_valid is also high; its result is
// registered in the head entry, or in the skid entry if the head is stalled.
// The whole check, pattern update and the four 48-bit saturating counter
// updates are done from the state registers as the word is taken. The result
// side is a two-entry buffer, so in_ready is low while both entries are full,
// whatever out_ready does, and comes back the cycle after the head word is
// taken. in_command = 1 clears all checker state (registers keep their values)
// and returns the cleared counters. Configuration writes take effect at once.
module prbs_bert_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [7:0]               in_data_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_locked,
  output logic [3:0]               out_byte_errors,
  output logic [pbc_pkg::CNT_W-1:0] out_bits_received,
  output logic [pbc_pkg::CNT_W-1:0] out_bits_in_sync,
  output logic [pbc_pkg::CNT_W-1:0] out_total_errors,
  output logic [pbc_pkg::CNT_W-1:0] out_sync_losses,
  input  logic                     cfg_wr_en,
  input  logic [pbc_pkg::CIDX_W-1:0] cfg_index,
  input  logic [pbc_pkg::CFG_W-1:0]  cfg_wdata
);
  import pbc_pkg::*;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                               input logic [3:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, v} + {{(CNT_W-3){1'b0}}, inc};
    if (sum[CNT_W]) begin
      return {CNT_W{1'b1}};
    end
    return sum[CNT_W-1:0];
  endfunction

  // configuration
  logic [1:0]        pn_mode_r;
  logic [7:0]        lock_thr_r;
  logic [7:0]        win_limit_r;
  logic [WERR_W-1:0] loss_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_mode_r   <= PN11;
      lock_thr_r  <= LOCK_THR_RST;
      win_limit_r <= WIN_LIMIT_RST;
      loss_thr_r  <= LOSS_THR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PN_MODE:   pn_mode_r   <= cfg_wdata[1:0];
        REG_LOCK_THR:  lock_thr_r  <= cfg_wdata[7:0];
        REG_WIN_LIMIT: win_limit_r <= cfg_wdata[7:0];
        REG_LOSS_THR:  loss_thr_r  <= cfg_wdata[WERR_W-1:0];
        default:       ;
      endcase
    end
  end

  // checker state
  logic [PAT_W-1:0]  pat_r,       pat_nxt;
  logic              sync_r,      sync_nxt;
  logic [7:0]        run_r,       run_nxt;
  logic [WCNT_W-1:0] wcnt_r,      wcnt_nxt;
  logic [WERR_W-1:0] werr_r,      werr_nxt;
  logic [CNT_W-1:0]  bits_r,      bits_nxt;
  logic [CNT_W-1:0]  sbits_r,     sbits_nxt;
  logic [CNT_W-1:0]  errs_r,      errs_nxt;
  logic [CNT_W-1:0]  loss_r,      loss_nxt;

  logic [PAT_W-1:0]  pat_m;
  logic [7:0]        predicted;
  logic [7:0]        rx;
  logic [7:0]        feed;
  logic [7:0]        diff;
  logic [3:0]        nerr;
  logic [WERR_W:0]   werr_sum;
  logic [WERR_W-1:0] werr_sat;
  res_t              res_nxt;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rx[i] = in_data_byte[7-i];
    end

    case (pn_mode_r)
      PN11:    pat_m = pat_r & MASK_PN11;
      PN15:    pat_m = pat_r & MASK_PN15;
      default: pat_m = pat_r & MASK_PN23;
    endcase

    case (pn_mode_r)
      PN11:    predicted = pat_m[7:0] ^ pat_m[9:2];
      PN15:    predicted = pat_m[7:0] ^ pat_m[8:1];
      default: predicted = pat_m[7:0] ^ pat_m[12:5];
    endcase

    diff = predicted ^ rx;
    nerr = '0;
    for (int i = 0; i < 8; i++) begin
      nerr = nerr + {3'b0, diff[i]};
    end

    werr_sum = {1'b0, werr_r} + {{(WERR_W-3){1'b0}}, nerr};
    werr_sat = werr_sum[WERR_W] ? {WERR_W{1'b1}} : werr_sum[WERR_W-1:0];

    sync_nxt  = sync_r;
    run_nxt   = run_r;
    wcnt_nxt  = wcnt_r;
    werr_nxt  = werr_r;
    bits_nxt  = sat_add(bits_r, 4'd8);
    sbits_nxt = sbits_r;
    errs_nxt  = errs_r;
    loss_nxt  = loss_r;
    feed      = predicted;
    res_nxt.byte_errors = '0;

    if (!sync_r) begin
      wcnt_nxt = '0;
      werr_nxt = '0;
      feed     = rx;
      if (predicted == rx) begin
        if (run_r >= lock_thr_r) begin
          sync_nxt = 1'b1;
          run_nxt  = '0;
        end else begin
          run_nxt = run_r + 8'd1;
        end
      end else begin
        run_nxt = '0;
      end
    end else begin
      sbits_nxt = sat_add(sbits_r, 4'd8);
      errs_nxt  = sat_add(errs_r, nerr);
      res_nxt.byte_errors = nerr;
      if (wcnt_r > {1'b0, win_limit_r}) begin
        wcnt_nxt = '0;
        werr_nxt = '0;
        if (werr_sat > loss_thr_r) begin
          sync_nxt = 1'b0;
          loss_nxt = sat_add(loss_r, 4'd1);
        end
      end else begin
        wcnt_nxt = wcnt_r + 9'd1;
        werr_nxt = werr_sat;
      end
    end

    // new bits enter above bit len-1, then the register shifts by 8
    case (pn_mode_r)
      PN11:    pat_nxt = {12'b0, feed, pat_m[10:8]};
      PN15:    pat_nxt = {8'b0, feed, pat_m[14:8]};
      default: pat_nxt = {feed, pat_m[22:8]};
    endcase

    if (in_command == CMD_CLEAR) begin
      pat_nxt   = {PAT_W{1'b1}};
      sync_nxt  = 1'b0;
      run_nxt   = '0;
      wcnt_nxt  = '0;
      werr_nxt  = '0;
      bits_nxt  = '0;
      sbits_nxt = '0;
      errs_nxt  = '0;
      loss_nxt  = '0;
      res_nxt.byte_errors = '0;
    end

    res_nxt.locked        = sync_nxt;
    res_nxt.bits_received = bits_nxt;
    res_nxt.bits_in_sync  = sbits_nxt;
    res_nxt.total_errors  = errs_nxt;
    res_nxt.sync_losses   = loss_nxt;
  end

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= {PAT_W{1'b1}};
      sync_r  <= 1'b0;
      run_r   <= '0;
      wcnt_r  <= '0;
      werr_r  <= '0;
      bits_r  <= '0;
      sbits_r <= '0;
      errs_r  <= '0;
      loss_r  <= '0;
    end else if (in_fire) begin
      pat_r   <= pat_nxt;
      sync_r  <= sync_nxt;
      run_r   <= run_nxt;
      wcnt_r  <= wcnt_nxt;
      werr_r  <= werr_nxt;
      bits_r  <= bits_nxt;
      sbits_r <= sbits_nxt;
      errs_r  <= errs_nxt;
      loss_r  <= loss_nxt;
    end
  end

  // two-entry result buffer: head drives the port, skid catches a stalled word
  logic out_valid_r;
  logic skid_valid_r;
  res_t out_r;
  res_t skid_r;
  logic out_pop;

  assign out_pop  = out_valid_r && out_ready;
  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_ready) begin
        skid_r <= res_nxt;
      end else begin
        out_r <= res_nxt;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_locked        = out_r.locked;
  assign out_byte_errors   = out_r.byte_errors;
  assign out_bits_received = out_r.bits_received;
  assign out_bits_in_sync  = out_r.bits_in_sync;
  assign out_total_errors  = out_r.total_errors;
  assign out_sync_losses   = out_r.sync_losses;

endmodule

// ----- rtl/pbc_checker.sv -----
`include "prbs_bert_checker_macros.svh"

module pbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [3:0]                 out_byte_errors,
  input logic [pbc_pkg::CNT_W-1:0]  out_bits_received,
  input logic [pbc_pkg::CNT_W-1:0]  out_bits_in_sync,
  input logic [pbc_pkg::CNT_W-1:0]  out_total_errors
);

  `PBC_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid, "output word valid after reset")

  `PBC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_total_errors), "stalled output word changed")

  `PBC_ASSERT(a_err_range, out_valid |-> out_byte_errors <= 4'd8, "byte error count above 8")

  `PBC_ASSERT(a_sync_le_rx, out_valid |-> out_bits_in_sync <= out_bits_received, "in-sync bits exceed received bits")

  `PBC_ASSERT(a_err_le_sync, out_valid |-> out_total_errors <= out_bits_in_sync, "errors exceed in-sync bits")

endmodule

bind prbs_bert_checker pbc_checker u_pbc_checker (.*);
